>>> design/frm_pkg.sv
// shared types, codes and reset constants of the frame rate meter
// used by every module of the block; no dependencies
package frm_pkg;

  localparam int unsigned HistoryLenDef = 60;
  localparam int unsigned DrawRateDef   = 30;

  localparam int unsigned RateW   = 10;
  localparam int unsigned CfgW    = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SmpW    = 16;

  localparam logic [RateW-1:0] RateLimit      = 10'd1000;
  localparam logic [SmpW-1:0]  TimeLimit      = 16'hFFFF;
  localparam logic [CfgW-1:0]  TickPeriodRst  = 10'd16;
  localparam logic [CfgW-1:0]  FramePeriodRst = 10'd33;
  localparam logic             CapLagRst      = 1'b1;

  // command codes
  localparam logic [1:0] CmdTick    = 2'd0;
  localparam logic [1:0] CmdFrame   = 2'd1;
  localparam logic [1:0] CmdRestart = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTickPeriod  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFramePeriod = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCapLag      = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] work_done_ms;
    logic [31:0] frame_end_ms;
  } in_item_t;

  typedef struct packed {
    logic             tick_granted;
    logic [RateW-1:0] draw_rate;
    logic [RateW-1:0] draw_rate_max;
    logic [31:0]      tick_count;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StDivide,
    StFinish
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } frm_ctrl_t;

  typedef struct packed {
    logic is_frame;
    logic div_busy;
  } frm_stat_t;

endpackage

>>> design/frm_rate_div.sv
// restoring divider: HISTORY_LEN*1000 / window sum, one quotient bit per cycle
// result clamped to the rate limit; depends on frm_pkg
module frm_rate_div import frm_pkg::*; #(
  parameter int unsigned HISTORY_LEN = HistoryLenDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [SmpW+$clog2(HISTORY_LEN)-1:0] divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [RateW-1:0]                    rate_o
);

  localparam int unsigned SumW     = SmpW + $clog2(HISTORY_LEN);
  localparam int unsigned Dividend = HISTORY_LEN * 1000;
  localparam int unsigned NumW     = $clog2(Dividend + 1);
  localparam int unsigned CntW     = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [SumW-1:0] div_q, div_d;

  logic [SumW:0]   trial;
  logic [SumW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      rem_d  = '0;
      quo_d  = NumW'(Dividend);
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[SumW-1:0] : trial[SumW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  // a zero divisor gives an all-ones quotient, which clamps as well
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rate_o = (quo_q > NumW'(RateLimit)) ? RateLimit : quo_q[RateW-1:0];

endmodule

>>> design/frm_datapath.sv
// datapath: config registers, frame time windows, running sums, tick credit,
// two rate dividers and the result register; depends on frm_pkg, frm_rate_div
module frm_datapath import frm_pkg::*; #(
  parameter int unsigned HISTORY_LEN = HistoryLenDef,
  parameter int unsigned DRAW_RATE   = DrawRateDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  in_item_t           in_item_i,
  input  frm_ctrl_t          ctrl_i,
  output frm_stat_t          stat_o,
  output out_item_t          out_item_o
);

  localparam int unsigned HeadW = $clog2(HISTORY_LEN);
  localparam int unsigned SumW  = SmpW + HeadW;
  localparam logic [RateW-1:0] DrawRateInit = RateW'(DRAW_RATE);
  localparam logic [SumW-1:0]  SumInit      = SumW'(HISTORY_LEN * FramePeriodRst);

  // configuration
  logic [CfgW-1:0] tick_period_q;
  logic [CfgW-1:0] frame_period_q;
  logic            cap_lag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q  <= TickPeriodRst;
      frame_period_q <= FramePeriodRst;
      cap_lag_q      <= CapLagRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTickPeriod:  tick_period_q  <= cfg_data_i;
        CfgFramePeriod: frame_period_q <= cfg_data_i;
        CfgCapLag:      cap_lag_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // captured item
  in_item_t in_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) in_q <= in_item_i;
  end

  // window memories, read at the head every cycle
  logic [SmpW-1:0] work_mem  [HISTORY_LEN];
  logic [SmpW-1:0] frame_mem [HISTORY_LEN];
  logic [SmpW-1:0] work_rd_q, frame_rd_q;

  logic [HeadW-1:0]       head_q;
  logic [HISTORY_LEN-1:0] work_vld_q, frame_vld_q;
  logic [CfgW-1:0]        fill_q;
  logic [SumW-1:0]        work_sum_q, frame_sum_q;
  logic [31:0]            last_q;
  logic [31:0]            credit_q;
  logic [31:0]            ticks_q;
  logic                   granted_q;
  logic [RateW-1:0]       rate_now_q, rate_peak_q;

  logic [31:0]     w, f;
  logic            w_nz, f_nz;
  logic [SmpW-1:0] w_smp, f_smp;
  logic [SmpW-1:0] work_old, frame_old;
  logic [SumW-1:0] work_sum_new, frame_sum_new;
  logic            is_frame;
  logic            work_we, frame_we;
  logic [CfgW:0]   cap2;
  logic [31:0]     add;
  logic [32:0]     credit_sum;
  logic [31:0]     credit_add;
  logic            tick_ok;

  logic             work_busy, frame_busy;
  logic             work_done, frame_done;
  logic [RateW-1:0] work_rate, frame_rate;

  assign is_frame = (in_q.cmd == CmdFrame);

  assign w     = in_q.work_done_ms - last_q;
  assign f     = in_q.frame_end_ms - last_q;
  assign w_nz  = |w;
  assign f_nz  = |f;
  assign w_smp = (|w[31:SmpW]) ? TimeLimit : w[SmpW-1:0];
  assign f_smp = (|f[31:SmpW]) ? TimeLimit : f[SmpW-1:0];

  // entries not written since reset or restart read as the refill value
  assign work_old  = work_vld_q[head_q]  ? work_rd_q  : SmpW'(fill_q);
  assign frame_old = frame_vld_q[head_q] ? frame_rd_q : SmpW'(fill_q);

  assign work_sum_new  = work_sum_q  - SumW'(work_old)  + SumW'(w_smp);
  assign frame_sum_new = frame_sum_q - SumW'(frame_old) + SumW'(f_smp);

  assign work_we  = ctrl_i.exec && is_frame && w_nz;
  assign frame_we = ctrl_i.exec && is_frame && f_nz;

  assign cap2       = {frame_period_q, 1'b0};
  assign add        = (cap_lag_q && (f > 32'(cap2))) ? 32'(cap2) : f;
  assign credit_sum = {1'b0, credit_q} + {1'b0, add};
  assign credit_add = credit_sum[32] ? '1 : credit_sum[31:0];
  assign tick_ok    = credit_q >= 32'(tick_period_q);

  always_ff @(posedge clk_i) begin
    if (work_we)  work_mem[head_q]  <= w_smp;
    if (frame_we) frame_mem[head_q] <= f_smp;
    work_rd_q  <= work_mem[head_q];
    frame_rd_q <= frame_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      work_vld_q  <= '0;
      frame_vld_q <= '0;
      fill_q      <= FramePeriodRst;
      work_sum_q  <= SumInit;
      frame_sum_q <= SumInit;
      last_q      <= '0;
      credit_q    <= 32'(TickPeriodRst);
      ticks_q     <= '0;
      granted_q   <= 1'b0;
      rate_now_q  <= DrawRateInit;
      rate_peak_q <= DrawRateInit;
    end else begin
      if (work_done)  rate_peak_q <= work_rate;
      if (frame_done) rate_now_q  <= frame_rate;
      if (ctrl_i.exec) begin
        granted_q <= (in_q.cmd == CmdTick) && tick_ok;
        unique case (in_q.cmd)
          CmdTick: begin
            if (tick_ok) begin
              credit_q <= credit_q - 32'(tick_period_q);
              ticks_q  <= ticks_q + 32'd1;
            end
          end
          CmdFrame: begin
            if (w_nz) begin
              work_sum_q         <= work_sum_new;
              work_vld_q[head_q] <= 1'b1;
            end
            if (f_nz) begin
              frame_sum_q         <= frame_sum_new;
              frame_vld_q[head_q] <= 1'b1;
            end
            head_q   <= (head_q == HeadW'(HISTORY_LEN - 1)) ? '0 : head_q + HeadW'(1);
            last_q   <= in_q.frame_end_ms;
            credit_q <= credit_add;
          end
          CmdRestart: begin
            work_vld_q  <= '0;
            frame_vld_q <= '0;
            fill_q      <= frame_period_q;
            work_sum_q  <= SumW'(HISTORY_LEN) * SumW'(frame_period_q);
            frame_sum_q <= SumW'(HISTORY_LEN) * SumW'(frame_period_q);
            rate_now_q  <= DrawRateInit;
            rate_peak_q <= DrawRateInit;
            credit_q    <= 32'(tick_period_q);
            last_q      <= in_q.frame_end_ms;
          end
          default: ;
        endcase
      end
    end
  end

  frm_rate_div #(.HISTORY_LEN(HISTORY_LEN)) u_work_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (work_we),
    .divisor_i (work_sum_new),
    .busy_o    (work_busy),
    .done_o    (work_done),
    .rate_o    (work_rate)
  );

  frm_rate_div #(.HISTORY_LEN(HISTORY_LEN)) u_frame_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (frame_we),
    .divisor_i (frame_sum_new),
    .busy_o    (frame_busy),
    .done_o    (frame_done),
    .rate_o    (frame_rate)
  );

  // busy until the quotient has landed in the rate register
  assign stat_o.is_frame = is_frame;
  assign stat_o.div_busy = work_busy | frame_busy | work_done | frame_done;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_item_o.tick_granted  <= granted_q;
      out_item_o.draw_rate     <= rate_now_q;
      out_item_o.draw_rate_max <= rate_peak_q;
      out_item_o.tick_count    <= ticks_q;
    end
  end

endmodule

>>> design/frm_ctrl.sv
// controller: sequences capture, update, divide wait and result hand-off
// depends on frm_pkg
module frm_ctrl import frm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  frm_stat_t stat_i,
  output frm_ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StExec;
      StExec:   state_d = stat_i.is_frame ? StDivide : StFinish;
      StDivide: if (!stat_i.div_busy) state_d = StFinish;
      StFinish: if (slot_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == StIdle);
    ctrl_o.capture  = (state_q == StIdle) && in_valid_i;
    ctrl_o.exec     = (state_q == StExec);
    ctrl_o.load_out = (state_q == StFinish) && slot_free;
    out_valid_d     = ctrl_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StExec))
    else $error("accepted item did not enter update");

  a_nonframe_skips_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && !stat_i.is_frame) |=> (state_q == StFinish))
    else $error("tick or restart went to divide wait");

  a_div_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide && !stat_i.div_busy) |=> (state_q == StFinish))
    else $error("divide wait not released");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");

endmodule

>>> design/frame_rate_meter_with_tick_credit.sv
// top level of the frame pacing monitor with tick credit
// depends on frm_pkg, frm_ctrl, frm_datapath (and frm_rate_div below it)
//
// usage: one input item per command on a valid/ready channel (tick request,
// frame end with two timestamps, restart); exactly one result item per input
// on a valid/ready output channel. configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i), to be written only while the block is
// idle; the block itself does not enforce this. tick request and restart
// go from the update step straight to the finish step; a frame end waits in
// the divide step for the bit-serial rate dividers that run for both windows
// in parallel. one item is in work at a time; the next item is accepted once
// the result is registered and the controller is back in its idle step.
// the result sits in an output register, so the next item is taken while it
// waits; if the receiver still stalls when the next result is ready, the
// block holds in its finish step until the register frees.
// reset: windows read as the reset frame period through per-entry valid
// bits, so no clearing pass is needed and an item is taken right after reset.
module frame_rate_meter_with_tick_credit import frm_pkg::*; #(
  parameter int unsigned HISTORY_LEN = HistoryLenDef,
  parameter int unsigned DRAW_RATE   = DrawRateDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  frm_ctrl_t ctrl;
  frm_stat_t stat;

  frm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  frm_datapath #(
    .HISTORY_LEN (HISTORY_LEN),
    .DRAW_RATE   (DRAW_RATE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

>>> bench/tb_frame_rate_meter_with_tick_credit.sv
`timescale 1ns / 100ps
// self-checking bench for frame_rate_meter_with_tick_credit: directed steps, then random traffic
// under four idling patterns, each result checked against a known value or a model of the meter kept here
// depends on frm_pkg and the top level of the block
module tb_frame_rate_meter_with_tick_credit;
  import frm_pkg::*;

  localparam int unsigned HistLen      = HistoryLenDef;
  localparam int unsigned DrawRate     = DrawRateDef;
  localparam int unsigned MsPerSec     = 1000;
  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned ItemsPerPhase = 236;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted   = 50;

  localparam logic [1:0]         CmdUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare  = 2'd3;

  typedef struct {
    bit                 is_write;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    reg_val;
    in_item_t           item;
    bit                 has_known;
    out_item_t          known;
  } pace_step_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item;

  // meter model state
  logic [CfgW-1:0]  m_tick_period;
  logic [CfgW-1:0]  m_frame_period;
  logic             m_cap;
  logic [SmpW-1:0]  m_full_win [HistLen];
  logic [SmpW-1:0]  m_work_win [HistLen];
  int unsigned      m_full_sum;
  int unsigned      m_work_sum;
  int unsigned      m_head;
  logic [31:0]      m_last_end;
  logic [31:0]      m_credit;
  logic [31:0]      m_ticks;
  logic [RateW-1:0] m_rate_now;
  logic [RateW-1:0] m_rate_peak;

  out_item_t   pending_readings[$];
  pace_step_t  directed_steps[$];
  logic [31:0] stim_clock = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned granted_seen = 0;
  int unsigned rate_limit_seen = 0;
  int unsigned sent_by_cmd [4] = '{0, 0, 0, 0};

  frame_rate_meter_with_tick_credit #(
    .HISTORY_LEN(HistLen),
    .DRAW_RATE  (DrawRate)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [RateW-1:0] rate_from_sum(int unsigned s);
    int unsigned q;
    if (s == 0) return RateLimit;
    q = (HistLen * MsPerSec) / s;
    if (q > MsPerSec) return RateLimit;
    return q[RateW-1:0];
  endfunction

  function automatic logic [SmpW-1:0] clip_ms(logic [31:0] d);
    return (d > {16'd0, TimeLimit}) ? TimeLimit : d[SmpW-1:0];
  endfunction

  function automatic void refill_windows();
    for (int i = 0; i < HistLen; i++) begin
      m_full_win[i] = {6'd0, m_frame_period};
      m_work_win[i] = {6'd0, m_frame_period};
    end
    m_full_sum  = HistLen * m_frame_period;
    m_work_sum  = m_full_sum;
    m_rate_now  = RateW'(DrawRate);
    m_rate_peak = RateW'(DrawRate);
    m_credit    = {22'd0, m_tick_period};
  endfunction

  function automatic void reset_meter_model();
    m_tick_period  = TickPeriodRst;
    m_frame_period = FramePeriodRst;
    m_cap          = CapLagRst;
    refill_windows();
    m_head     = 0;
    m_last_end = '0;
    m_ticks    = '0;
  endfunction

  function automatic out_item_t predict_meter(in_item_t it);
    out_item_t   r;
    logic [31:0] w_ms, f_ms, add, lag_cap;
    logic [SmpW-1:0] s;
    r = '0;
    if (it.cmd == CmdTick) begin
      if (m_credit >= {22'd0, m_tick_period}) begin
        m_credit = m_credit - {22'd0, m_tick_period};
        m_ticks++;
        r.tick_granted = 1'b1;
      end
    end else if (it.cmd == CmdFrame) begin
      w_ms = it.work_done_ms - m_last_end;
      f_ms = it.frame_end_ms - m_last_end;
      // an elapsed time of zero leaves its window alone
      if (w_ms != 0) begin
        s = clip_ms(w_ms);
        m_work_sum = m_work_sum - m_work_win[m_head] + s;
        m_work_win[m_head] = s;
        m_rate_peak = rate_from_sum(m_work_sum);
      end
      if (f_ms != 0) begin
        s = clip_ms(f_ms);
        m_full_sum = m_full_sum - m_full_win[m_head] + s;
        m_full_win[m_head] = s;
        m_rate_now = rate_from_sum(m_full_sum);
      end
      m_head     = (m_head + 1) % HistLen;
      m_last_end = it.frame_end_ms;
      add     = f_ms;
      lag_cap = {21'd0, m_frame_period, 1'b0};
      if (m_cap && add > lag_cap) add = lag_cap;
      m_credit = (m_credit > 32'hFFFF_FFFF - add) ? 32'hFFFF_FFFF : m_credit + add;
    end else if (it.cmd == CmdRestart) begin
      refill_windows();
      m_last_end = it.frame_end_ms;
    end
    r.draw_rate     = m_rate_now;
    r.draw_rate_max = m_rate_peak;
    r.tick_count    = m_ticks;
    return r;
  endfunction

  function automatic void add_cmd(logic [1:0] cmd, logic [31:0] work_t, logic [31:0] end_t);
    pace_step_t st;
    st = '{default: '0};
    st.item = '{cmd: cmd, work_done_ms: work_t, frame_end_ms: end_t};
    directed_steps.push_back(st);
  endfunction

  function automatic void add_known(logic [1:0] cmd, logic [31:0] work_t, logic [31:0] end_t,
                                    logic granted, logic [RateW-1:0] rate,
                                    logic [RateW-1:0] rate_max, logic [31:0] count);
    pace_step_t st;
    st = '{default: '0};
    st.item      = '{cmd: cmd, work_done_ms: work_t, frame_end_ms: end_t};
    st.has_known = 1'b1;
    st.known     = '{tick_granted: granted, draw_rate: rate, draw_rate_max: rate_max,
                     tick_count: count};
    directed_steps.push_back(st);
  endfunction

  function automatic void add_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    pace_step_t st;
    st = '{default: '0};
    st.is_write = 1'b1;
    st.reg_idx  = idx;
    st.reg_val  = val;
    directed_steps.push_back(st);
  endfunction

  function automatic logic [CfgW-1:0] pick_setting();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 10'd1;
      2:       return '1;
      3:       return 10'd1000;
      default: return CfgW'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgTickPeriod:  m_tick_period = val;
      CfgFramePeriod: m_frame_period = val;
      CfgCapLag:      m_cap = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // sender stops and waits until every result is back
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_command(in_item_t it, bit has_known, out_item_t known);
    out_item_t want;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      if (in_valid) in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    want = predict_meter(it);
    pending_readings.push_back(has_known ? known : want);
    sent_by_cmd[it.cmd]++;
    if (it.cmd == CmdFrame || it.cmd == CmdRestart) stim_clock = it.frame_end_ms;
  endtask

  // mostly paced frames around the nominal period with ticks in between
  task automatic make_pacing_item(output in_item_t it);
    int unsigned pick, span;
    logic [31:0] d_end, d_work;
    pick = $urandom_range(0, 99);
    span = 3 * m_frame_period + 4;
    it.work_done_ms = $urandom;
    it.frame_end_ms = $urandom;
    if (pick < 44) begin
      it.cmd = CmdTick;
    end else if (pick < 84) begin
      it.cmd = CmdFrame;
      d_end = $urandom_range(0, span);
      if ($urandom_range(0, 19) == 0) d_end = $urandom_range(60000, 300000);
      d_work = $urandom_range(0, d_end);
      it.work_done_ms = stim_clock + d_work;
      it.frame_end_ms = stim_clock + d_end;
    end else if (pick < 90) begin
      // work stamp unchanged or later than the frame end
      it.cmd = CmdFrame;
      d_end = $urandom_range(0, span);
      it.work_done_ms = $urandom_range(0, 1) ? stim_clock
                                             : stim_clock + d_end + $urandom_range(1, 50);
      it.frame_end_ms = stim_clock + d_end;
    end else if (pick < 94) begin
      it.cmd = CmdFrame;
    end else if (pick < 97) begin
      it.cmd = CmdRestart;
      if ($urandom_range(0, 1)) it.frame_end_ms = stim_clock + $urandom_range(0, span);
    end else begin
      it.cmd = CmdUnused;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", out_item));
      end else begin
        want = pending_readings.pop_front();
        checked++;
        if (want.tick_granted) granted_seen++;
        if (want.draw_rate == RateLimit) rate_limit_seen++;
        if (out_item.tick_granted !== want.tick_granted)
          report_mismatch($sformatf("tick_granted got %0b expected %0b",
                                    out_item.tick_granted, want.tick_granted));
        if (out_item.draw_rate !== want.draw_rate)
          report_mismatch($sformatf("draw_rate got %0d expected %0d",
                                    out_item.draw_rate, want.draw_rate));
        if (out_item.draw_rate_max !== want.draw_rate_max)
          report_mismatch($sformatf("draw_rate_max got %0d expected %0d",
                                    out_item.draw_rate_max, want.draw_rate_max));
        if (out_item.tick_count !== want.tick_count)
          report_mismatch($sformatf("tick_count got %0d expected %0d",
                                    out_item.tick_count, want.tick_count));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycle_count, pending_readings.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    reset_meter_model();

    // after reset the credit covers exactly one tick
    add_known(CmdTick, '0, '0, 1'b1, 10'd30, 10'd30, 32'd1);
    add_known(CmdTick, '1, '1, 1'b0, 10'd30, 10'd30, 32'd1);
    add_known(CmdUnused, '1, '1, 1'b0, 10'd30, 10'd30, 32'd1);
    // both stamps equal the last frame end: no sample stored
    add_known(CmdFrame, '0, '0, 1'b0, 10'd30, 10'd30, 32'd1);
    add_cmd(CmdFrame, 32'd10, 32'd20);
    add_cmd(CmdFrame, '1, '1);
    add_cmd(CmdTick, '0, '0);
    add_known(CmdRestart, '0, 32'd1000, 1'b0, 10'd30, 10'd30, 32'd2);
    add_write(CfgCapLag, 10'd0);
    add_write(CfgTickPeriod, 10'd0);
    add_known(CmdTick, '0, '0, 1'b1, 10'd30, 10'd30, 32'd3);
    // frame time wraps to all ones, uncapped credit saturates
    add_cmd(CmdFrame, 32'd1005, 32'd999);
    add_cmd(CmdTick, '1, '0);
    add_write(CfgFramePeriod, 10'd1);
    add_write(CfgTickPeriod, '1);
    add_write(CfgCapLag, 10'd1);
    add_write(CfgSpare, '1);
    add_known(CmdRestart, '1, '0, 1'b0, 10'd30, 10'd30, 32'd4);
    add_known(CmdFrame, 32'd1, 32'd1, 1'b0, RateLimit, RateLimit, 32'd4);
    add_cmd(CmdTick, '0, '1);
    add_write(CfgFramePeriod, 10'd0);
    add_known(CmdRestart, '0, 32'd5, 1'b0, 10'd30, 10'd30, 32'd5);
    add_cmd(CmdFrame, 32'd5, 32'd6);
    add_cmd(CmdFrame, 32'd6, 32'd6);
    add_write(CfgFramePeriod, 10'd1000);
    add_write(CfgTickPeriod, 10'd1);
    add_cmd(CmdRestart, '0, 32'd100);
    add_cmd(CmdFrame, 32'd40100, 32'd70100);
    add_cmd(CmdTick, '0, '0);
    add_cmd(CmdUnused, 32'h5A5A_A5A5, 32'hA5A5_5A5A);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        drain_results();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_command(directed_steps[i].item, directed_steps[i].has_known,
                     directed_steps[i].known);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      write_reg(CfgTickPeriod, pick_setting());
      write_reg(CfgFramePeriod, pick_setting());
      write_reg(CfgCapLag, CfgW'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) write_reg(CfgSpare, CfgW'($urandom));
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (k == ItemsPerPhase / 2 && ph % 3 == 1) drain_results();
        make_pacing_item(it);
        send_command(it, 1'b0, '0);
      end
    end

    if (in_valid) in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d items: %0d tick, %0d frame, %0d restart, %0d unused; %0d results checked",
             sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3], sent_by_cmd[0],
             sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3], checked);
    $display("%0d ticks granted, %0d results at the rate limit, %0d mismatches",
             granted_seen, rate_limit_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/frm_pkg.sv
design/frm_rate_div.sv
design/frm_datapath.sv
design/frm_ctrl.sv
design/frame_rate_meter_with_tick_credit.sv
bench/tb_frame_rate_meter_with_tick_credit.sv
